// ----- src/bilinear_pixel_sampler_macros.svh -----
// Assertion macros used by the bilinear pixel sampler back end.
`ifndef BILINEAR_PIXEL_SAMPLER_MACROS_SVH
`define BILINEAR_PIXEL_SAMPLER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BPS_ASSERT_IMPLIES(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BPS_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- src/bps_pkg.sv -----
// Shared types and constants of the bilinear pixel sampler.
package bps_pkg;

  localparam int BPS_MAX_COLS  = 512;
  localparam int BPS_MAX_ROWS  = 512;
  localparam int BPS_FRAC_BITS = 8;

  localparam int CFG_W       = 10;
  localparam int POS_W       = 18;
  localparam int PIX_W       = 8;
  localparam int COORD_IN_W  = 9;
  localparam int IDX_W       = POS_W - 1;
  localparam int COORD_W     = 12;
  localparam int FRAC_MAX_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int MIN_DIM     = 2;
  localparam int DIM_RESET   = 512;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  localparam logic CFG_IDX_COLS = 1'b0;
  localparam logic CFG_IDX_ROWS = 1'b1;

  typedef struct packed {
    logic                  wr;
    logic                  err;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    logic [PIX_W-1:0]      value;
    logic [FRAC_MAX_W-1:0] fu;
    logic [FRAC_MAX_W-1:0] fv;
  } bps_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bps_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_MIX,
    ST_OUT
  } bps_state_t;

endpackage

// ----- src/bps_front.sv -----
// Front end: configuration registers, transaction intake and classification.
module bps_front import bps_pkg::*; #(
  parameter int MAX_COLS  = BPS_MAX_COLS,
  parameter int MAX_ROWS  = BPS_MAX_ROWS,
  parameter int FRAC_BITS = BPS_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    action,
  input  logic [COORD_IN_W-1:0]   pixel_col,
  input  logic [COORD_IN_W-1:0]   pixel_row,
  input  logic [PIX_W-1:0]        pixel_value,
  input  logic signed [POS_W-1:0] pos_u,
  input  logic signed [POS_W-1:0] pos_v,
  input  bps_qstat_t              qstat,
  output logic                    push,
  output bps_item_t               item
);

  logic [CFG_W-1:0] image_cols;
  logic [CFG_W-1:0] image_rows;

  logic [IDX_W-1:0] cols_raw, rows_raw, cols_eff, rows_eff;
  logic [IDX_W-1:0] cx, cy, wcol, wrow;
  logic             negative, outside, in_store, accept, is_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= CFG_W'(DIM_RESET);
      image_rows <= CFG_W'(DIM_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IDX_COLS: image_cols <= cfg_data;
        CFG_IDX_ROWS: image_rows <= cfg_data;
      endcase
    end
  end

  always_comb begin
    // clamp the image size into the range the store supports
    cols_raw = IDX_W'(image_cols);
    rows_raw = IDX_W'(image_rows);
    if (cols_raw < IDX_W'(MIN_DIM))       cols_eff = IDX_W'(MIN_DIM);
    else if (cols_raw > IDX_W'(MAX_COLS)) cols_eff = IDX_W'(MAX_COLS);
    else                                  cols_eff = cols_raw;
    if (rows_raw < IDX_W'(MIN_DIM))       rows_eff = IDX_W'(MIN_DIM);
    else if (rows_raw > IDX_W'(MAX_ROWS)) rows_eff = IDX_W'(MAX_ROWS);
    else                                  rows_eff = rows_raw;

    cx       = IDX_W'(pos_u[POS_W-2:FRAC_BITS]);
    cy       = IDX_W'(pos_v[POS_W-2:FRAC_BITS]);
    negative = pos_u[POS_W-1] | pos_v[POS_W-1];
    outside  = (cx >= cols_eff - IDX_W'(1)) | (cy >= rows_eff - IDX_W'(1));

    wcol     = IDX_W'(pixel_col);
    wrow     = IDX_W'(pixel_row);
    in_store = (wcol < IDX_W'(MAX_COLS)) & (wrow < IDX_W'(MAX_ROWS));

    is_write = (action == ACT_WRITE);
    accept   = start & ~qstat.full;
    // drop writes that fall outside the store
    push     = accept & (~is_write | in_store);

    item.wr    = is_write;
    item.err   = ~is_write & (negative | outside);
    item.col   = is_write ? COORD_W'(wcol) : COORD_W'(cx);
    item.row   = is_write ? COORD_W'(wrow) : COORD_W'(cy);
    item.value = pixel_value;
    item.fu    = FRAC_MAX_W'(pos_u[FRAC_BITS-1:0]);
    item.fv    = FRAC_MAX_W'(pos_v[FRAC_BITS-1:0]);
  end

endmodule

// ----- src/bps_queue.sv -----
// Short FIFO between the front end and the back end.
module bps_queue import bps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bps_item_t  din,
  input  logic       pop,
  output bps_item_t  dout,
  output bps_qstat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bps_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign dout       = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- src/bps_back.sv -----
// Back end: pixel store, neighbour fetch sequencer and bilinear blend.
`include "bilinear_pixel_sampler_macros.svh"

module bps_back import bps_pkg::*; #(
  parameter int MAX_COLS  = BPS_MAX_COLS,
  parameter int MAX_ROWS  = BPS_MAX_ROWS,
  parameter int FRAC_BITS = BPS_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  bps_item_t        head,
  input  bps_qstat_t       qstat,
  output logic             pop,
  output logic             done,
  output logic [PIX_W-1:0] sample_value,
  output logic             status
);

  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int AW        = COL_W + ROW_W;
  localparam int MEM_DEPTH = MAX_ROWS * (2 ** COL_W);
  localparam int W_W       = FRAC_BITS + 1;
  localparam int H_W       = PIX_W + FRAC_BITS;
  localparam int ACC_W     = PIX_W + 2 * FRAC_BITS;

  bps_state_t state, state_next;
  bps_item_t  cur;

  logic [PIX_W-1:0] mem [MEM_DEPTH];
  logic [PIX_W-1:0] rdata;
  logic [H_W-1:0]   h;
  logic [ACC_W-1:0] acc;

  logic             mem_we;
  logic [AW-1:0]    addr;
  logic [COL_W-1:0] col_a;
  logic [ROW_W-1:0] row_a;
  logic             starts_fetch;

  logic [W_W-1:0]       one, wu0, wu1, wv0, wv1, px_w, row_w;
  logic [PIX_W+W_W-1:0] px_full;
  logic [H_W+W_W-1:0]   row_full;
  logic [H_W-1:0]       h_add, h_next;
  logic [ACC_W-1:0]     acc_total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE, ST_OUT: state_next = starts_fetch ? ST_RD1 : ST_IDLE;
      ST_RD1:          state_next = ST_RD2;
      ST_RD2:          state_next = ST_RD3;
      ST_RD3:          state_next = ST_MIX;
      ST_MIX:          state_next = ST_OUT;
      default:         state_next = ST_IDLE;
    endcase
  end

  // control outputs and store address
  always_comb begin
    pop          = ~qstat.empty &
                   ((state == ST_IDLE) | ((state == ST_OUT) & ~head.err));
    starts_fetch = pop & ~head.wr & ~head.err;
    mem_we       = pop & head.wr;
    col_a        = cur.col[COL_W-1:0];
    row_a        = cur.row[ROW_W-1:0];
    unique case (state)
      ST_IDLE, ST_OUT: begin
        col_a = head.col[COL_W-1:0];
        row_a = head.row[ROW_W-1:0];
      end
      ST_RD1: col_a = cur.col[COL_W-1:0] + COL_W'(1);
      ST_RD2: row_a = cur.row[ROW_W-1:0] + ROW_W'(1);
      ST_RD3: begin
        col_a = cur.col[COL_W-1:0] + COL_W'(1);
        row_a = cur.row[ROW_W-1:0] + ROW_W'(1);
      end
      default: ;
    endcase
    addr = {row_a, col_a};
  end

  // blend datapath: pixel times horizontal weight, then row sum times vertical weight
  always_comb begin
    one       = W_W'(1) << FRAC_BITS;
    wu1       = W_W'(cur.fu[FRAC_BITS-1:0]);
    wv1       = W_W'(cur.fv[FRAC_BITS-1:0]);
    wu0       = one - wu1;
    wv0       = one - wv1;
    px_w      = ((state == ST_RD1) || (state == ST_RD3)) ? wu0 : wu1;
    px_full   = rdata * px_w;
    h_add     = ((state == ST_RD2) || (state == ST_MIX)) ? h : '0;
    h_next    = h_add + px_full[H_W-1:0];
    row_w     = (state == ST_OUT) ? wv1 : wv0;
    row_full  = h * row_w;
    acc_total = acc + row_full[ACC_W-1:0];
  end

  // single-port pixel store
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= head.value;
    else        rdata     <= mem[addr];
  end

  always_ff @(posedge clk) begin
    h <= h_next;
    if (state == ST_RD3) acc <= row_full[ACC_W-1:0];
    if (pop)             cur <= head;
    if (state == ST_OUT) begin
      sample_value <= acc_total[2*FRAC_BITS +: PIX_W];
      status       <= STAT_OK;
    end else begin
      sample_value <= '0;
      status       <= STAT_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (pop & head.err) | (state == ST_OUT);
    end
  end

  `BPS_ASSERT_IMPLIES(a_err_value_zero, done && status == STAT_ERR, sample_value == '0, "error result with non-zero value")
  `BPS_ASSERT_IMPLIES(a_no_pop_mid_fetch, state == ST_RD1 || state == ST_RD2 || state == ST_RD3 || state == ST_MIX, !pop, "pop during neighbour fetch")
  `BPS_ASSERT_NEXT(a_fetch_starts, pop && !head.wr && !head.err, state == ST_RD1, "valid sample did not start fetch")
  `BPS_ASSERT_NEXT(a_idle_write_silent, state == ST_IDLE && pop && head.wr, !done, "pixel write produced a result")
  `BPS_ASSERT_IMPLIES(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")

endmodule

// ----- src/bilinear_pixel_sampler.sv -----
// Top level of the bilinear pixel sampler: front end, queue and back end.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ---------------------------------------------
//   input     start / busy         action, pixel_col, pixel_row, pixel_value,
//                                  pos_u, pos_v
//   result    done (one cycle)     sample_value, status
//   config    cfg_write            cfg_index, cfg_data
//
// A write leaves the queue with no result; an out-of-area sample leaves and its error result
// follows on the next cycle. A valid sample holds the back end through states RD1, RD2, RD3,
// MIX and OUT (four single-ported store reads, one per cycle, then the vertical blend), result
// next. A write or valid sample behind it leaves in OUT; an out-of-area one waits for IDLE, so
// two results never share a cycle. busy rises only with the two-entry queue full. Synchronous
// reset sets 512 x 512, keeps the store; the receiver cannot stall.
module bilinear_pixel_sampler import bps_pkg::*; #(
  parameter int MAX_COLS  = BPS_MAX_COLS,
  parameter int MAX_ROWS  = BPS_MAX_ROWS,
  parameter int FRAC_BITS = BPS_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    action,
  input  logic [COORD_IN_W-1:0]   pixel_col,
  input  logic [COORD_IN_W-1:0]   pixel_row,
  input  logic [PIX_W-1:0]        pixel_value,
  input  logic signed [POS_W-1:0] pos_u,
  input  logic signed [POS_W-1:0] pos_v,
  output logic                    done,
  output logic [PIX_W-1:0]        sample_value,
  output logic                    status,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  bps_item_t  front_item, head_item;
  bps_qstat_t qstat;
  logic       push, pop;

  // front end: hold the image size and classify each accepted transaction
  bps_front #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .pixel_value (pixel_value),
    .pos_u       (pos_u),
    .pos_v       (pos_v),
    .qstat       (qstat),
    .push        (push),
    .item        (front_item)
  );

  // decouple intake from the store sequencer
  bps_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_item),
    .pop  (pop),
    .dout (head_item),
    .stat (qstat)
  );

  // back end: write pixels, fetch neighbours and blend
  bps_back #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_item),
    .qstat        (qstat),
    .pop          (pop),
    .done         (done),
    .sample_value (sample_value),
    .status       (status)
  );

  // hold off new transactions while the queue is full
  assign busy = qstat.full;

endmodule
